// File: rtl/core/rbst_pkg.sv
// Shared constants and types for the ray versus box slab test.
// No dependencies.
package rbst_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int CFG_ADDR_W      = 3;
    localparam int AXES            = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_BOX_MIN_X = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BOX_MIN_Y = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BOX_MIN_Z = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BOX_MAX_X = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BOX_MAX_Y = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_BOX_MAX_Z = 3'd5;

    // per-axis flags that travel alongside the dividers
    typedef struct packed {
        logic [AXES-1:0] neg_lo;
        logic [AXES-1:0] neg_hi;
        logic [AXES-1:0] dzero;
        logic [AXES-1:0] outslab;
    } rbst_side_t;

endpackage

// File: rtl/core/rbst_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating.
// Depends on rbst_pkg.
module rbst_div import rbst_pkg::*; #(
    parameter int W = COORD_WIDTH_DEF,
    parameter int F = FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [W+F:0]         num,
    input  logic [W-1:0]         den,
    output logic [W-2:0]         q
);

    localparam int NUMW = W + 1 + F;

    logic [W-2:0]  rem_a [0:NUMW];
    logic [NUMW-1:0] num_a [0:NUMW];
    logic [W-1:0]  den_a [0:NUMW];
    logic [W-2:0]  q_a   [0:NUMW];
    logic          ovf_a [0:NUMW];

    assign rem_a[0] = '0;
    assign num_a[0] = num;
    assign den_a[0] = den;
    assign q_a[0]   = '0;
    assign ovf_a[0] = 1'b0;

    genvar k;
    generate
        for (k = 0; k < NUMW; k++) begin : g_stage
            logic [W-1:0] trial;
            logic         ge;
            logic [W-1:0] diff;
            always_comb
            begin
                trial = {rem_a[k], num_a[k][NUMW-1]};
                ge    = (trial >= den_a[k]);
                diff  = trial - den_a[k];
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_a[k+1] <= ge ? diff[W-2:0] : trial[W-2:0];
                    num_a[k+1] <= num_a[k] << 1;
                    den_a[k+1] <= den_a[k];
                    q_a[k+1]   <= {q_a[k][W-3:0], ge};
                    ovf_a[k+1] <= ovf_a[k] | (ge && ((NUMW - 1 - k) >= (W - 1)));
                end
            end
        end
    endgenerate

    assign q = ovf_a[NUMW] ? {(W-1){1'b1}} : q_a[NUMW];

endmodule

// File: rtl/core/rbst_eval.sv
// Back end: signs the slab parameters, folds entry and exit, decides hit.
// Depends on rbst_pkg.
module rbst_eval import rbst_pkg::*; #(
    parameter int W = COORD_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_vld,
    input  rbst_side_t   side,
    input  logic [W-2:0] q_lo [AXES],
    input  logic [W-2:0] q_hi [AXES],
    output logic         out_vld,
    output logic         hit
);

    localparam logic signed [W-1:0] LIM = {1'b0, {(W-1){1'b1}}};

    logic                a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg;
    logic signed [W-1:0] t_lo_reg [AXES];
    logic signed [W-1:0] t_hi_reg [AXES];
    logic [AXES-1:0]     a_dzero_reg, a_out_reg;
    logic signed [W-1:0] nr_reg [AXES];
    logic signed [W-1:0] fr_reg [AXES];
    logic [AXES-1:0]     b_dzero_reg, b_out_reg;
    logic signed [W-1:0] entry_reg, exit_reg, entry_next, exit_next;
    logic                inside_reg, zmiss_reg, hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
        end
    end

    genvar a;
    generate
        for (a = 0; a < AXES; a++) begin : g_axis
            logic signed [W-1:0] pl, ph;
            assign pl = $signed({1'b0, q_lo[a]});
            assign ph = $signed({1'b0, q_hi[a]});
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    t_lo_reg[a] <= side.neg_lo[a] ? -pl : pl;
                    t_hi_reg[a] <= side.neg_hi[a] ? -ph : ph;
                    if (a_dzero_reg[a])
                    begin
                        nr_reg[a] <= '0;
                        fr_reg[a] <= LIM;
                    end
                    else if (t_lo_reg[a] < t_hi_reg[a])
                    begin
                        nr_reg[a] <= t_lo_reg[a];
                        fr_reg[a] <= t_hi_reg[a];
                    end
                    else
                    begin
                        nr_reg[a] <= t_hi_reg[a];
                        fr_reg[a] <= t_lo_reg[a];
                    end
                end
            end
        end
    endgenerate

    always_comb
    begin
        entry_next = '0;
        exit_next  = LIM;
        for (int i = 0; i < AXES; i++)
        begin
            if (nr_reg[i] > entry_next)
                entry_next = nr_reg[i];
            if (fr_reg[i] < exit_next)
                exit_next = fr_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_dzero_reg <= side.dzero;
            a_out_reg   <= side.outslab;
            b_dzero_reg <= a_dzero_reg;
            b_out_reg   <= a_out_reg;
            entry_reg   <= entry_next;
            exit_reg    <= exit_next;
            inside_reg  <= ~|b_out_reg;
            zmiss_reg   <= |(b_out_reg & b_dzero_reg);
            hit_reg     <= inside_reg | (!zmiss_reg && (entry_reg <= exit_reg));
        end
    end

    assign out_vld = d_vld_reg;
    assign hit     = hit_reg;

endmodule

// File: rtl/core/ray_box_slab_test.sv
// Top level of the ray versus axis-aligned box slab test.
// Depends on rbst_pkg, rbst_div and rbst_eval.
//
// Takes one ray per cycle unless stalled and returns one hit bit per ray, in
// order. Six dividers resolve one quotient bit per stage; one front-end stage
// comes before them and four back-end stages follow. Coordinates default to
// Q16.16. The whole pipeline stalls while a result waits at the output. Box
// registers are sampled as a ray enters.
module ray_box_slab_test import rbst_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [COORD_WIDTH-1:0]        cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] origin_x,
    input  logic signed [COORD_WIDTH-1:0] origin_y,
    input  logic signed [COORD_WIDTH-1:0] origin_z,
    input  logic signed [COORD_WIDTH-1:0] dir_x,
    input  logic signed [COORD_WIDTH-1:0] dir_y,
    input  logic signed [COORD_WIDTH-1:0] dir_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          hit
);

    localparam int W    = COORD_WIDTH;
    localparam int NUMW = COORD_WIDTH + 1 + FRAC_BITS;

    logic signed [W-1:0] box_lo_reg [AXES];
    logic signed [W-1:0] box_hi_reg [AXES];
    logic signed [W-1:0] org [AXES];
    logic signed [W-1:0] dir [AXES];

    logic                en;
    logic                pre_vld_reg;
    logic [NUMW-1:0]     num_lo_reg [AXES];
    logic [NUMW-1:0]     num_hi_reg [AXES];
    logic [W-1:0]        den_reg [AXES];
    rbst_side_t          pre_side_reg;
    rbst_side_t          side_next;

    logic [NUMW-1:0]     vld_pipe_reg;
    rbst_side_t          side_pipe_reg [NUMW];
    logic [W-2:0]        q_lo [AXES];
    logic [W-2:0]        q_hi [AXES];

    assign org[0] = origin_x;
    assign org[1] = origin_y;
    assign org[2] = origin_z;
    assign dir[0] = dir_x;
    assign dir[1] = dir_y;
    assign dir[2] = dir_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                box_lo_reg[i] <= '0;
                box_hi_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_BOX_MIN_X: box_lo_reg[0] <= cfg_data;
                REG_BOX_MIN_Y: box_lo_reg[1] <= cfg_data;
                REG_BOX_MIN_Z: box_lo_reg[2] <= cfg_data;
                REG_BOX_MAX_X: box_hi_reg[0] <= cfg_data;
                REG_BOX_MAX_Y: box_hi_reg[1] <= cfg_data;
                REG_BOX_MAX_Z: box_hi_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    genvar a;
    generate
        for (a = 0; a < AXES; a++) begin : g_front
            logic signed [W:0] d_lo, d_hi;
            logic [W:0]        m_lo, m_hi;
            assign d_lo = {box_lo_reg[a][W-1], box_lo_reg[a]} - {org[a][W-1], org[a]};
            assign d_hi = {box_hi_reg[a][W-1], box_hi_reg[a]} - {org[a][W-1], org[a]};
            assign m_lo = d_lo[W] ? (~d_lo + 1'b1) : d_lo;
            assign m_hi = d_hi[W] ? (~d_hi + 1'b1) : d_hi;
            assign side_next.neg_lo[a]  = d_lo[W] ^ dir[a][W-1];
            assign side_next.neg_hi[a]  = d_hi[W] ^ dir[a][W-1];
            assign side_next.dzero[a]   = (dir[a] == '0);
            assign side_next.outslab[a] = (org[a] < box_lo_reg[a]) || (org[a] > box_hi_reg[a]);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_lo_reg[a] <= NUMW'(m_lo) << FRAC_BITS;
                    num_hi_reg[a] <= NUMW'(m_hi) << FRAC_BITS;
                    den_reg[a]    <= dir[a][W-1] ? (~dir[a] + 1'b1) : dir[a];
                end
            end

            rbst_div #(.W(W), .F(FRAC_BITS)) u_div_lo (
                .clk (clk),
                .en  (en),
                .num (num_lo_reg[a]),
                .den (den_reg[a]),
                .q   (q_lo[a])
            );

            rbst_div #(.W(W), .F(FRAC_BITS)) u_div_hi (
                .clk (clk),
                .en  (en),
                .num (num_hi_reg[a]),
                .den (den_reg[a]),
                .q   (q_hi[a])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_vld_reg  <= 1'b0;
            vld_pipe_reg <= '0;
        end
        else if (en)
        begin
            pre_vld_reg  <= in_valid;
            vld_pipe_reg <= {vld_pipe_reg[NUMW-2:0], pre_vld_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_side_reg     <= side_next;
            side_pipe_reg[0] <= pre_side_reg;
            for (int i = 1; i < NUMW; i++)
                side_pipe_reg[i] <= side_pipe_reg[i-1];
        end
    end

    rbst_eval #(.W(W)) u_eval (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (vld_pipe_reg[NUMW-1]),
        .side    (side_pipe_reg[NUMW-1]),
        .q_lo    (q_lo),
        .q_hi    (q_hi),
        .out_vld (out_valid),
        .hit     (hit)
    );

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> pre_vld_reg)
        else $error("accepted ray did not enter the front stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_pipe_reg) && $stable(pre_vld_reg))
        else $error("pipeline moved during a stall");

    a_bubble_stays: assert property (@(posedge clk) disable iff (!rst_n)
        en && !in_valid |=> !pre_vld_reg)
        else $error("front stage valid without a transfer");

endmodule
